FILE: rtl/core/laplace_stencil_filter_macros.svh
// Assertion macros shared by the stencil filter modules.
`ifndef LAPLACE_STENCIL_FILTER_MACROS_SVH
`define LAPLACE_STENCIL_FILTER_MACROS_SVH

// Same-cycle implication check.
`define LSF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("stencil filter check failed");

// Next-cycle implication check.
`define LSF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("stencil filter sequence check failed");

`endif

FILE: rtl/core/lsf_pkg.sv
// Package with the types and fixed constants of the stencil filter.
`default_nettype none
package lsf_pkg;

  localparam int IDX_W     = 5;
  localparam int COEFF_W   = 18;
  localparam int SAMPLE_W  = 16;
  localparam int LAP_W     = 48;
  localparam int CCOL_W    = 12;
  localparam int CROW_W    = 16;
  localparam int GW_W      = 13;
  localparam int GH_W      = 16;
  localparam int RADC_W    = 2;
  localparam int INV_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int PROD_W    = COEFF_W + SAMPLE_W;
  localparam int FRAC_SH   = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP_SQ = 2'd3;

  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_SAMPLE = 1'b1;

  localparam logic [LAP_W-1:0] LAP_MAX = {1'b0, {(LAP_W-1){1'b1}}};
  localparam logic [LAP_W-1:0] LAP_MIN = {1'b1, {(LAP_W-1){1'b0}}};

  typedef struct packed {
    logic                       is_sample;
    logic [IDX_W-1:0]           idx;
    logic signed [COEFF_W-1:0]  coeff;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [GW_W-1:0]   grid_width;
    logic [GH_W-1:0]   grid_height;
    logic [RADC_W-1:0] radius;
    logic [INV_W-1:0]  inv_step_sq;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/lsf_ram.sv
// Generic single-write, registered-read RAM.
`default_nettype none
module lsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lsf_front.sv
// Front end: accepts input beats, classifies them and queues commands.
`default_nettype none
`include "laplace_stencil_filter_macros.svh"
module lsf_front #(
  parameter int MAX_RADIUS = 2
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_action,
  input  wire logic [lsf_pkg::IDX_W-1:0]          in_coeff_index,
  input  wire logic signed [lsf_pkg::COEFF_W-1:0] in_coeff_value,
  input  wire logic signed [lsf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                    q_valid,
  output lsf_pkg::cmd_t                           q_cmd,
  input  wire logic                               q_pop
);

  localparam int TAPS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

  lsf_pkg::cmd_t ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          keep, push;
  lsf_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.is_sample = (in_action == lsf_pkg::ACTION_SAMPLE);
    cmd_in.idx       = in_coeff_index;
    cmd_in.coeff     = in_coeff_value;
    cmd_in.sample    = in_sample;
    keep = cmd_in.is_sample || (32'(in_coeff_index) < TAPS);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  `LSF_ASSERT_NXT(a_push_grows, clk, rst_n, push && !q_pop, cnt_r == $past(cnt_r) + 2'd1)
  `LSF_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, cnt_r != 2'd0)
  `LSF_ASSERT_NXT(a_drop_load, clk, rst_n, in_valid && in_ready && !keep && !q_pop,
                  cnt_r == $past(cnt_r))

endmodule
`default_nettype wire

FILE: rtl/core/lsf_back.sv
// Back end: line buffers, window, serial multiply-accumulate and scaling.
`default_nettype none
`include "laplace_stencil_filter_macros.svh"
module lsf_back #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_RADIUS = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lsf_pkg::cfg_t                cfg,
  input  wire logic                         q_valid,
  input  wire lsf_pkg::cmd_t                q_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [lsf_pkg::LAP_W-1:0]         out_laplacian,
  output logic [lsf_pkg::CCOL_W-1:0]        out_center_col,
  output logic [lsf_pkg::CROW_W-1:0]        out_center_row,
  output logic                              out_frame_last
);

  localparam int SPAN  = 2 * MAX_RADIUS + 1;
  localparam int TAPS  = SPAN * SPAN;
  localparam int LINES = 2 * MAX_RADIUS;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int TI    = $clog2(TAPS);
  localparam int SW    = $clog2(SPAN);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int DW    = $clog2(SPAN + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W = lsf_pkg::PROD_W + $clog2(TAPS);
  localparam int MUL_W = SUM_W + 16;
  localparam int SMP_W = lsf_pkg::SAMPLE_W;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SHIFT = 8'b0000_0010,
    ST_MAC   = 8'b0000_0100,
    ST_DRAIN = 8'b0000_1000,
    ST_SC1   = 8'b0001_0000,
    ST_SC2   = 8'b0010_0000,
    ST_SC3   = 8'b0100_0000,
    ST_SC4   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [lsf_pkg::COEFF_W-1:0] coeff_r [TAPS];
  logic signed [SMP_W-1:0]            win_r [SPAN][SPAN];
  logic [AW-1:0]                      col_cnt_r;
  logic [lsf_pkg::CROW_W-1:0]         row_cnt_r;
  lsf_pkg::cmd_t                      cur_r;

  logic [TI-1:0]                      ci_r;
  logic [SW-1:0]                      wr_r, wc_r;
  logic signed [lsf_pkg::PROD_W-1:0]  prod_r;
  logic                               prod_vld_r;
  logic signed [SUM_W-1:0]            acc_r;
  logic                               neg_r;
  logic [SUM_W-1:0]                   mag_r;
  logic [MUL_W-1:0]                   lo_r, hi_r;
  logic                               sat_r;
  logic [63:0]                        full_r;

  logic [lsf_pkg::CCOL_W-1:0]         ccol_r;
  logic [lsf_pkg::CROW_W-1:0]         crow_r;
  logic                               last_r;
  logic                               out_valid_r;
  logic [lsf_pkg::LAP_W-1:0]          lap_r;

  logic [RW-1:0]   rad;
  logic [DW-1:0]   d, l;
  logic [WW-1:0]   w;
  logic [lsf_pkg::GH_W-1:0] h;
  logic            emit, last_pt, wrap_col, last_tap, out_load;
  logic [SMP_W-1:0] rd [LINES];
  logic signed [SMP_W-1:0] col_v [SPAN];
  logic [63:0]     q_pos, q_neg, neg_val;
  logic [lsf_pkg::LAP_W-1:0] res;

  always_comb begin
    if (cfg.radius == '0) begin
      rad = RW'(1);
    end else if (32'(cfg.radius) > MAX_RADIUS) begin
      rad = RW'(MAX_RADIUS);
    end else begin
      rad = RW'(cfg.radius);
    end
    d = DW'(2 * 32'(rad) + 1);
    l = DW'(2 * 32'(rad));
    if (32'(cfg.grid_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else if (cfg.grid_width == '0) begin
      w = WW'(1);
    end else begin
      w = WW'(cfg.grid_width);
    end
    h        = (cfg.grid_height == '0) ? lsf_pkg::GH_W'(1) : cfg.grid_height;
    emit     = (32'(row_cnt_r) >= 32'(l)) && (32'(col_cnt_r) >= 32'(l));
    wrap_col = (32'(col_cnt_r) + 1 >= 32'(w));
    last_pt  = wrap_col && (32'(row_cnt_r) + 1 >= 32'(h));
    last_tap = (32'(wr_r) + 1 == 32'(d)) && (32'(wc_r) + 1 == 32'(d));
  end

  always_comb begin
    for (int k = 0; k < SPAN; k++) begin
      col_v[k] = cur_r.sample;
      if (k < LINES) begin
        if (32'(k) < 32'(l)) begin
          col_v[k] = $signed(rd[k]);
        end
      end
    end
  end

  for (genvar k = 0; k < LINES; k++) begin : g_line
    logic [SMP_W-1:0] wdat;
    if (k + 1 < LINES) begin : g_mid
      assign wdat = (32'(k) + 1 < 32'(l)) ? rd[k+1] : cur_r.sample;
    end else begin : g_end
      assign wdat = cur_r.sample;
    end
    lsf_ram #(
      .WIDTH(SMP_W),
      .DEPTH(MAX_WIDTH)
    ) u_line (
      .clk  (clk),
      .we   ((state_r == ST_SHIFT) && (32'(k) < 32'(l))),
      .waddr(col_cnt_r),
      .wdata(wdat),
      .re   (q_pop && q_cmd.is_sample),
      .raddr(col_cnt_r),
      .rdata(rd[k])
    );
  end

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_load = (state_r == ST_SC4) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_cmd.is_sample) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: state_nxt = emit ? ST_MAC : ST_IDLE;
      ST_MAC: begin
        if (last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_SC1;
      ST_SC1:   state_nxt = ST_SC2;
      ST_SC2:   state_nxt = ST_SC3;
      ST_SC3:   state_nxt = ST_SC4;
      ST_SC4: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        coeff_r[i] <= '0;
      end
      for (int i = 0; i < SPAN; i++) begin
        for (int j = 0; j < SPAN; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (q_pop && !q_cmd.is_sample) begin
        coeff_r[TI'(q_cmd.idx)] <= q_cmd.coeff;
      end
      if (state_r == ST_SHIFT) begin
        for (int i = 0; i < SPAN; i++) begin
          for (int j = 0; j < SPAN; j++) begin
            if (32'(i) < 32'(d)) begin
              if (32'(j) + 1 < 32'(d)) begin
                if (j + 1 < SPAN) begin
                  win_r[i][j] <= win_r[i][j+1];
                end
              end else if (32'(j) + 1 == 32'(d)) begin
                win_r[i][j] <= col_v[i];
              end
            end
          end
        end
        if (wrap_col) begin
          col_cnt_r <= '0;
          row_cnt_r <= last_pt ? '0 : row_cnt_r + 1'b1;
        end else begin
          col_cnt_r <= col_cnt_r + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    unique case (state_r)
      ST_SHIFT: begin
        ci_r       <= '0;
        wr_r       <= '0;
        wc_r       <= '0;
        acc_r      <= '0;
        prod_vld_r <= 1'b0;
        ccol_r     <= lsf_pkg::CCOL_W'(32'(col_cnt_r) - 32'(rad));
        crow_r     <= lsf_pkg::CROW_W'(32'(row_cnt_r) - 32'(rad));
        last_r     <= last_pt;
      end
      ST_MAC: begin
        prod_r     <= coeff_r[ci_r] * win_r[wr_r][wc_r];
        prod_vld_r <= 1'b1;
        acc_r      <= acc_r + (prod_vld_r ? SUM_W'(prod_r) : '0);
        ci_r       <= ci_r + 1'b1;
        if (32'(wc_r) + 1 == 32'(d)) begin
          wc_r <= '0;
          wr_r <= wr_r + 1'b1;
        end else begin
          wc_r <= wc_r + 1'b1;
        end
      end
      ST_DRAIN: acc_r <= acc_r + SUM_W'(prod_r);
      ST_SC1: begin
        neg_r <= acc_r[SUM_W-1];
        mag_r <= acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);
      end
      ST_SC2: begin
        lo_r <= mag_r * cfg.inv_step_sq[15:0];
        hi_r <= mag_r * cfg.inv_step_sq[31:16];
      end
      ST_SC3: begin
        sat_r  <= (64'(hi_r) >= (64'(1) << 45));
        full_r <= (64'(hi_r) << 16) + 64'(lo_r);
      end
      ST_SC4: begin
        if (out_load) begin
          lap_r          <= res;
          out_center_col <= ccol_r;
          out_center_row <= crow_r;
          out_frame_last <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    q_pos   = full_r >> lsf_pkg::FRAC_SH;
    q_neg   = (full_r + 64'h3FFF) >> lsf_pkg::FRAC_SH;
    neg_val = 64'(0) - q_neg;
    if (sat_r) begin
      res = neg_r ? lsf_pkg::LAP_MIN : lsf_pkg::LAP_MAX;
    end else if (!neg_r) begin
      res = (q_pos > 64'(lsf_pkg::LAP_MAX)) ? lsf_pkg::LAP_MAX : q_pos[lsf_pkg::LAP_W-1:0];
    end else begin
      res = (q_neg > (64'(1) << 47)) ? lsf_pkg::LAP_MIN : neg_val[lsf_pkg::LAP_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_laplacian = lap_r;

  `LSF_ASSERT_NXT(a_emit_mac, clk, rst_n, (state_r == ST_SHIFT) && emit, state_r == ST_MAC)
  `LSF_ASSERT_IMP(a_out_from_sc4, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_SC4))
  `LSF_ASSERT_NXT(a_frame_wrap, clk, rst_n, (state_r == ST_SHIFT) && last_pt,
                  (col_cnt_r == '0) && (row_cnt_r == '0))

endmodule
`default_nettype wire

FILE: rtl/core/laplace_stencil_filter.sv
// Top level of the streaming two-dimensional stencil filter.
//
//  channel | direction | beat contents
//  in_     | input     | action, coefficient slot and value, grid sample
//  out_    | output    | scaled stencil sum, centre column and row, frame end
//  cfg_    | input     | register index and write data, no read-back
//
// In the back end a coefficient load is written while idle. A grid sample
// shifts the window, and when it completes an interior window the serial
// multiply-accumulate over the window and the scaling steps follow.
// Synchronous reset clears counters, window and coefficients.
// A two-entry queue lets input beats be taken while the back end works, and
// the back end waits only when an unconsumed result still holds the output.
`default_nettype none
module laplace_stencil_filter #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_RADIUS = 2
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_action,
  input  wire logic [lsf_pkg::IDX_W-1:0]           in_coeff_index,
  input  wire logic signed [lsf_pkg::COEFF_W-1:0]  in_coeff_value,
  input  wire logic signed [lsf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [lsf_pkg::LAP_W-1:0]         out_laplacian,
  output logic [lsf_pkg::CCOL_W-1:0]               out_center_col,
  output logic [lsf_pkg::CROW_W-1:0]               out_center_row,
  output logic                                     out_frame_last,
  input  wire logic                                cfg_we,
  input  wire logic [lsf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lsf_pkg::CFG_DAT_W-1:0]       cfg_data
);

  lsf_pkg::cfg_t cfg_r;
  logic          q_valid, q_pop;
  lsf_pkg::cmd_t q_cmd;
  logic [lsf_pkg::LAP_W-1:0] lap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width  <= lsf_pkg::GW_W'(4096);
      cfg_r.grid_height <= lsf_pkg::GH_W'(1024);
      cfg_r.radius      <= lsf_pkg::RADC_W'(1);
      cfg_r.inv_step_sq <= lsf_pkg::INV_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsf_pkg::CFG_GRID_WIDTH:  cfg_r.grid_width  <= cfg_data[lsf_pkg::GW_W-1:0];
        lsf_pkg::CFG_GRID_HEIGHT: cfg_r.grid_height <= cfg_data[lsf_pkg::GH_W-1:0];
        lsf_pkg::CFG_RADIUS:      cfg_r.radius      <= cfg_data[lsf_pkg::RADC_W-1:0];
        lsf_pkg::CFG_INV_STEP_SQ: cfg_r.inv_step_sq <= cfg_data[lsf_pkg::INV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lsf_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_coeff_index(in_coeff_index),
    .in_coeff_value(in_coeff_value),
    .in_sample     (in_sample),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  lsf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_laplacian (lap),
    .out_center_col(out_center_col),
    .out_center_row(out_center_row),
    .out_frame_last(out_frame_last)
  );

  assign out_laplacian = $signed(lap);

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the streaming two-dimensional stencil filter.
`default_nettype none
class stencil_scoreboard;
  typedef struct {
    logic signed [47:0] lap;
    logic [11:0]        ccol;
    logic [15:0]        crow;
    logic               last;
  } stencil_result_t;

  logic signed [17:0] coeff_tab[25];
  logic signed [15:0] line_mem[4][4096];
  logic signed [15:0] win[5][5];
  int unsigned        col_cnt, row_cnt;
  logic [12:0]        width_reg;
  logic [15:0]        height_reg;
  logic [1:0]         radius_reg;
  logic [31:0]        scale_reg;
  stencil_result_t    laplacian_q[$];
  int                 mismatches;

  function new();
    foreach (coeff_tab[i]) coeff_tab[i] = '0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = 13'd4096;
    height_reg = 16'd1024;
    radius_reg = 2'd1;
    scale_reg = 32'd1;
    mismatches = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      lsf_pkg::CFG_GRID_WIDTH:  width_reg = data[12:0];
      lsf_pkg::CFG_GRID_HEIGHT: height_reg = data[15:0];
      lsf_pkg::CFG_RADIUS:      radius_reg = data[1:0];
      default:                  scale_reg = data;
    endcase
  endfunction

  function logic signed [47:0] scale_and_clip(longint acc);
    logic signed [95:0] a, b, p;
    a = acc;
    b = {64'd0, scale_reg};
    p = (a * b) >>> 14;
    if (p > 96'sh7FFF_FFFF_FFFF) return lsf_pkg::LAP_MAX;
    if (p < -96'sh8000_0000_0000) return lsf_pkg::LAP_MIN;
    return p[47:0];
  endfunction

  function void note_input(logic act, logic [4:0] idx, logic signed [17:0] cv,
                           logic signed [15:0] smp);
    logic signed [15:0] colv[5];
    int unsigned rad, d, l, w, h, c, r;
    longint acc;
    stencil_result_t res;
    if (act == lsf_pkg::ACTION_LOAD) begin
      if (idx < 25) coeff_tab[idx] = cv;
      return;
    end
    rad = radius_reg == 0 ? 1 : (radius_reg > 2 ? 2 : radius_reg);
    d = 2 * rad + 1;
    l = 2 * rad;
    w = width_reg > 4096 ? 4096 : (width_reg == 0 ? 1 : width_reg);
    h = height_reg == 0 ? 1 : height_reg;
    c = col_cnt < 4096 ? col_cnt : 0;
    r = row_cnt;
    for (int k = 0; k < l; k++) colv[k] = line_mem[k][c];
    colv[l] = smp;
    for (int k = 0; k + 1 < l; k++) line_mem[k][c] = colv[k+1];
    line_mem[l-1][c] = colv[l];
    for (int wr = 0; wr < d; wr++) begin
      for (int wc = 0; wc + 1 < d; wc++) win[wr][wc] = win[wr][wc+1];
      win[wr][d-1] = colv[wr];
    end
    if (r >= l && c >= l) begin
      acc = 0;
      for (int wr = 0; wr < d; wr++)
        for (int wc = 0; wc < d; wc++)
          acc += longint'(coeff_tab[wr*d+wc]) * longint'(win[wr][wc]);
      res.lap = scale_and_clip(acc);
      res.ccol = 12'(c - rad);
      res.crow = 16'(r - rad);
      res.last = (c + 1 >= w) && (r + 1 >= h);
      laplacian_q.push_back(res);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function void check_result(logic signed [47:0] lap, logic [11:0] ccol,
                             logic [15:0] crow, logic last);
    stencil_result_t e;
    if (laplacian_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result beat: lap=%0d col=%0d row=%0d",
                                     lap, ccol, crow);
      return;
    end
    e = laplacian_q.pop_front();
    if (e.lap !== lap || e.ccol !== ccol || e.crow !== crow || e.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected lap=%0d col=%0d row=%0d last=%0b, got %0d %0d %0d %0b",
                 e.lap, e.ccol, e.crow, e.last, lap, ccol, crow, last);
    end
  endfunction
endclass

module tb_top;
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_action = 1'b0;
  logic [4:0]         in_coeff_index = '0;
  logic signed [17:0] in_coeff_value = '0;
  logic signed [15:0] in_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [47:0] out_laplacian;
  logic [11:0]        out_center_col;
  logic [15:0]        out_center_row;
  logic               out_frame_last;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  stencil_scoreboard sb = new();
  int burst_left = 0;
  int samples_seen = 0;
  int quiet_cycles = 0;
  int random_items = 0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  laplace_stencil_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_coeff_index(in_coeff_index), .in_coeff_value(in_coeff_value),
    .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_laplacian(out_laplacian),
    .out_center_col(out_center_col), .out_center_row(out_center_row),
    .out_frame_last(out_frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random or not at all, and once long enough to fill the block.
  always @(posedge clk) begin
    if (!hold_done && samples_seen == 20) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ((samples_seen / 97) % 3 == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= $urandom_range(0, 3) != 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_laplacian, out_center_col, out_center_row, out_frame_last);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_beat(logic act, logic [4:0] idx, logic signed [17:0] cv,
                           logic signed [15:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_coeff_index <= idx;
    in_coeff_value <= cv;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, idx, cv, smp);
    if (act == lsf_pkg::ACTION_SAMPLE) samples_seen++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.laplacian_q.size() != 0);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_grid(logic [31:0] w, logic [31:0] h, logic [31:0] rad,
                          logic [31:0] k);
    logic [31:0] vals[4];
    vals = '{w, h, rad, k};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(2'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(int n, int load_pct, bit counted);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < load_pct) begin
        send_beat(lsf_pkg::ACTION_LOAD, 5'($urandom), 18'($urandom), 16'($urandom));
      end else begin
        send_beat(lsf_pkg::ACTION_SAMPLE, 5'($urandom), 18'($urandom), pick_sample());
        sent++;
      end
      if (counted) random_items++;
    end
  endtask

  initial begin
    int w, h;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_grid(3, 3, 1, 1);
    for (int i = 0; i < 9; i++)
      send_beat(lsf_pkg::ACTION_LOAD, 5'(i), i[0] ? 18'sh1FFFF : -18'sh20000, '0);
    send_beat(lsf_pkg::ACTION_LOAD, 5'd25, 18'sh1FFFF, '0);
    send_beat(lsf_pkg::ACTION_LOAD, 5'd31, -18'sh20000, '0);
    for (int i = 0; i < 9; i++)
      send_beat(lsf_pkg::ACTION_SAMPLE, '0, '0, i[0] ? 16'sh7FFF : 16'sh8000);
    drain();

    set_grid(7, 6, 2, 32'hFFFF_FFFF);
    send_frame(42, 15, 1'b0);
    drain();
    set_grid(8191, 3, 0, 0);
    send_frame(60, 0, 1'b0);
    drain();
    set_grid(0, 65535, 3, 5);
    send_frame(30, 0, 1'b0);
    drain();
    set_grid(6, 0, 1, 7);
    send_frame(6, 10, 1'b0);
    drain();
    set_grid(4, 4, 2, 3);
    send_frame(16, 10, 1'b0);
    drain();

    while (random_items < 220) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 10);
      set_grid(w, h, $urandom_range(1, 2),
               $urandom_range(0, 1) ? $urandom_range(0, 70000) : $urandom);
      send_frame(w * h, 8, 1'b1);
      drain();
    end

    drain();
    if (sb.mismatches == 0 && sb.laplacian_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
